// ===== hw/rtl/rme_pkg.sv =====
// Package: payload types and constants for the rotation-matrix-to-Euler core.
package rme_pkg;

  localparam int ONE_Q14 = 16384;
  localparam int ANG_W = 16;
  localparam int TBL_LEN = 16;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               gimbal_locked;
  } out_t;

  function automatic logic [15:0] atan_tbl(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:  r = 16'd8192;
      5'd1:  r = 16'd4836;
      5'd2:  r = 16'd2555;
      5'd3:  r = 16'd1297;
      5'd4:  r = 16'd651;
      5'd5:  r = 16'd326;
      5'd6:  r = 16'd163;
      5'd7:  r = 16'd81;
      5'd8:  r = 16'd41;
      5'd9:  r = 16'd20;
      5'd10: r = 16'd10;
      5'd11: r = 16'd5;
      5'd12: r = 16'd3;
      5'd13: r = 16'd1;
      5'd14: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/rotation_matrix_to_euler_xyz_core.sv =====
// Top level: rotation matrix (Q1.14) to XYZ Euler binary angles.
// One transaction is accepted every cycle (busy stays low). Each result appears
// on out_* with out_valid for one cycle, after passing through these registers in order:
// one input stage, the square root (an input register and 15 stages), then the
// CORDIC pipeline (CORDIC_STAGES+1 registers) and one output register. Roll and
// yaw operands wait in delay registers alongside the square root. The receiver
// cannot stall; results must be taken when shown.
module rotation_matrix_to_euler_xyz_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rme_pkg::in_t         in_data,
  output logic                 out_valid,
  output rme_pkg::out_t        out_data,
  input  logic                 cfg_we,
  input  logic [14:0]          cfg_gimbal_limit
);
  localparam int SQ = 15;

  logic [14:0] lim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) lim_r <= 15'd16384;
    else if (cfg_we) lim_r <= cfg_gimbal_limit;
  end

  assign busy = 1'b0;

  // stage 0: clamp and branch selection
  logic signed [15:0] s_nxt;
  logic [14:0]        mag_nxt;
  logic               lock_nxt;
  always_comb begin
    if (in_data.m02 < -16'sd16384) s_nxt = 16'sd16384;
    else if (in_data.m02 > 16'sd16384) s_nxt = -16'sd16384;
    else s_nxt = -in_data.m02;
    mag_nxt  = s_nxt[15] ? 15'(-s_nxt) : 15'(s_nxt);
    lock_nxt = mag_nxt >= lim_r;
  end

  logic               v0_r, lock0_r;
  logic signed [15:0] s0_r;
  logic signed [16:0] xy0_r, xx0_r, zy0_r, zx0_r;
  logic [28:0]        sq_in;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
    s0_r    <= s_nxt;
    lock0_r <= lock_nxt;
    if (lock_nxt) begin
      xy0_r <= (s_nxt > 0) ? 17'(in_data.m10) : -17'(in_data.m10);
      xx0_r <= 17'(in_data.m11);
    end else begin
      xy0_r <= 17'(in_data.m12);
      xx0_r <= 17'(in_data.m22);
    end
    zy0_r <= 17'(in_data.m01);
    zx0_r <= 17'(in_data.m00);
  end

  logic [29:0] ss;
  assign ss    = 30'($signed(s0_r) * $signed(s0_r));
  assign sq_in = 29'(30'd268435456 - ss);

  logic        sq_vld;
  logic [14:0] sq_root;
  rme_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_vld(v0_r), .in_v(sq_in),
    .out_vld(sq_vld), .out_root(sq_root)
  );

  logic signed [15:0] s_d  [SQ+1];
  logic               lk_d [SQ+1];
  logic signed [16:0] a_d [SQ+1], b_d [SQ+1], c_d [SQ+1], e_d [SQ+1];
  always_ff @(posedge clk) begin
    s_d[0] <= s0_r; lk_d[0] <= lock0_r;
    a_d[0] <= xy0_r; b_d[0] <= xx0_r; c_d[0] <= zy0_r; e_d[0] <= zx0_r;
  end
  for (genvar i = 0; i < SQ; i++) begin : g_dly
    always_ff @(posedge clk) begin
      s_d[i+1] <= s_d[i]; lk_d[i+1] <= lk_d[i];
      a_d[i+1] <= a_d[i]; b_d[i+1] <= b_d[i];
      c_d[i+1] <= c_d[i]; e_d[i+1] <= e_d[i];
    end
  end

  logic        vy, vx, vz;
  logic [15:0] ang_y, ang_x, ang_z;
  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cy (
    .clk(clk), .rst_n(rst_n), .in_vld(sq_vld),
    .in_y(17'(s_d[SQ])), .in_x({2'b00, sq_root}),
    .out_vld(vy), .out_ang(ang_y)
  );
  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cx (
    .clk(clk), .rst_n(rst_n), .in_vld(sq_vld),
    .in_y(a_d[SQ]), .in_x(b_d[SQ]),
    .out_vld(vx), .out_ang(ang_x)
  );
  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cz (
    .clk(clk), .rst_n(rst_n), .in_vld(sq_vld),
    .in_y(c_d[SQ]), .in_x(e_d[SQ]),
    .out_vld(vz), .out_ang(ang_z)
  );

  // lock flag follows the CORDIC latency
  logic lk_c [CORDIC_STAGES+1];
  always_ff @(posedge clk) lk_c[0] <= lk_d[SQ];
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lk
    always_ff @(posedge clk) lk_c[i+1] <= lk_c[i];
  end

  logic signed [15:0] ay_sat;
  always_comb begin
    ay_sat = $signed(ang_y);
    if (ay_sat > 16'sd16384) ay_sat = 16'sd16384;
    else if (ay_sat < -16'sd16384) ay_sat = -16'sd16384;
  end

  logic          ov_r;
  rme_pkg::out_t od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= vy & vx & vz;
    od_r.angle_x       <= $signed(ang_x);
    od_r.angle_y       <= ay_sat;
    od_r.angle_z       <= lk_c[CORDIC_STAGES] ? 16'sd0 : $signed(ang_z);
    od_r.gimbal_locked <= lk_c[CORDIC_STAGES];
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

// ===== hw/rtl/rme_cordic.sv =====
// Pipelined vectoring CORDIC atan2, one stage per iteration.
module rme_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [16:0] in_y,
  input  logic signed [16:0] in_x,
  output logic               out_vld,
  output logic [15:0]        out_ang
);
  // 17-bit operand * 4096 -> 29 bits; growth by 1.65 plus sign -> 32 bits
  localparam int W = 32;

  logic signed [W-1:0] x_r [STAGES+1];
  logic signed [W-1:0] y_r [STAGES+1];
  logic [15:0]         a_r [STAGES+1];
  logic                z_r [STAGES+1];
  logic                v_r [STAGES+1];

  logic signed [W-1:0] x0_nxt, y0_nxt;
  always_comb begin
    x0_nxt = W'(in_x) <<< 12;
    y0_nxt = W'(in_y) <<< 12;
    if (in_x < 0) begin
      x0_nxt = -x0_nxt;
      y0_nxt = -y0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
    end
    x_r[0] <= x0_nxt;
    y_r[0] <= y0_nxt;
    a_r[0] <= (in_x < 0) ? 16'h8000 : 16'h0000;
    z_r[0] <= (in_x == 0) && (in_y == 0);
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    logic [15:0] t;
    assign t = (i < rme_pkg::TBL_LEN) ? rme_pkg::atan_tbl(5'(i)) : 16'd0;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + t;
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - t;
      end
      z_r[i+1] <= z_r[i];
    end
  end

  assign out_vld = v_r[STAGES];
  assign out_ang = z_r[STAGES] ? 16'd0 : a_r[STAGES];
endmodule

// ===== hw/rtl/rme_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module rme_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [28:0] in_v,
  output logic        out_vld,
  output logic [14:0] out_root
);
  localparam int N = 15;
  logic [29:0] rem_r  [N+1];
  logic [14:0] root_r [N+1];
  logic        v_r    [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= in_vld;
    rem_r[0]  <= {1'b0, in_v};
    root_r[0] <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_b
    localparam int B = N - 1 - i;
    logic [29:0] trial;
    assign trial = ({15'd0, root_r[i]} << (B + 1)) | (30'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else v_r[i+1] <= v_r[i];
      if (rem_r[i] >= trial) begin
        rem_r[i+1]  <= rem_r[i] - trial;
        root_r[i+1] <= root_r[i] | (15'd1 << B);
      end else begin
        rem_r[i+1]  <= rem_r[i];
        root_r[i+1] <= root_r[i];
      end
    end
  end

  assign out_vld  = v_r[N];
  assign out_root = root_r[N];
endmodule

// ===== hw/rtl/rme_checker.sv =====
// Port-level checker for the Euler core, with its bind.
module rme_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          busy,
  input logic          out_valid,
  input rme_pkg::out_t out_data
);
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");
  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle_y <= 16'sd16384 && out_data.angle_y >= -16'sd16384))
    else $error("pitch out of range");
  a_yaw_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.gimbal_locked) |-> out_data.angle_z == 16'sd0)
    else $error("yaw nonzero in lock");
endmodule

bind rotation_matrix_to_euler_xyz_core rme_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid), .out_data(out_data)
);

// ===== tb/sv/rotation_matrix_to_euler_xyz_core_tb.sv =====
// Testbench for the rotation-matrix-to-Euler core: queue-fed driver, predicted-angle checks.
module rotation_matrix_to_euler_xyz_core_tb;

  localparam int STAGES  = 16;
  localparam int LATENCY = STAGES + 18;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rme_pkg::in_t in_data = '0;
  logic out_valid;
  rme_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [14:0] cfg_gimbal_limit = 15'd16384;

  rme_pkg::in_t  matrix_q[$];
  rme_pkg::out_t angles_q[$];
  logic [14:0] limit_model = 15'd16384;
  int errors = 0;
  int gap_left = 0;
  bit idle_en = 1'b1;
  bit hold = 1'b0;

  rotation_matrix_to_euler_xyz_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_gimbal_limit(cfg_gimbal_limit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] tab(int i);
    int t[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return (i < 16) ? t[i][15:0] : 16'd0;
  endfunction

  function automatic logic signed [15:0] vec_atan2(longint y, longint x);
    logic [15:0] a;
    longint xs;
    longint ys;
    a = '0;
    if (x == 0 && y == 0) return 16'sd0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = 16'h8000;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        a = a + tab(i);
      end else begin
        x = x - ys;
        y = y + xs;
        a = a - tab(i);
      end
    end
    return a;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic rme_pkg::out_t predict_angles(rme_pkg::in_t m);
    rme_pkg::out_t o;
    longint s;
    longint ay;
    longint mag;
    s = -longint'(m.m02);
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    ay = vec_atan2(s, int_sqrt(64'd268435456 - s * s));
    if (ay > 16384) ay = 16384;
    if (ay < -16384) ay = -16384;
    o.angle_y = ay[15:0];
    mag = (s < 0) ? -s : s;
    o.gimbal_locked = mag >= longint'(limit_model);
    if (!o.gimbal_locked) begin
      o.angle_x = vec_atan2(m.m12, m.m22);
      o.angle_z = vec_atan2(m.m01, m.m00);
    end else begin
      o.angle_x = (s > 0) ? vec_atan2(m.m10, m.m11) : vec_atan2(-longint'(m.m10), m.m11);
      o.angle_z = '0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst_n && start && !busy) angles_q.insert(angles_q.size(), predict_angles(in_data));
    if (rst_n && (!start || !busy)) begin
      if (matrix_q.size() != 0 && !hold && gap_left == 0 &&
          !(idle_en && $urandom_range(0, 15) == 0)) begin
        start <= 1'b1;
        in_data <= matrix_q.pop_front();
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (idle_en && matrix_q.size() != 0 && $urandom_range(0, 19) == 0)
          gap_left <= $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    rme_pkg::out_t exp_o;
    if (rst_n && out_valid) begin
      if (angles_q.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
      end else begin
        exp_o = angles_q.pop_front();
        if (out_data.angle_x !== exp_o.angle_x) begin
          $error("angle_x exp %0d got %0d", exp_o.angle_x, out_data.angle_x);
          errors++;
        end
        if (out_data.angle_y !== exp_o.angle_y) begin
          $error("angle_y exp %0d got %0d", exp_o.angle_y, out_data.angle_y);
          errors++;
        end
        if (out_data.angle_z !== exp_o.angle_z) begin
          $error("angle_z exp %0d got %0d", exp_o.angle_z, out_data.angle_z);
          errors++;
        end
        if (out_data.gimbal_locked !== exp_o.gimbal_locked) begin
          $error("gimbal_locked exp %0b got %0b", exp_o.gimbal_locked,
                 out_data.gimbal_locked);
          errors++;
        end
      end
    end
  end

  function automatic logic [15:0] rnd_entry();
    case ($urandom_range(0, 9))
      0: return 16'd16384;
      1: return -16'sd16384;
      2: return 16'($urandom());
      3: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic rme_pkg::in_t rnd_matrix();
    rme_pkg::in_t m;
    m = {rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry(),
         rnd_entry(), rnd_entry()};
    if ($urandom_range(0, 5) == 0) m.m02 = 16'($urandom_range(0, 400) + 16000);
    if ($urandom_range(0, 5) == 0) m.m02 = 16'(-16384 - int'($urandom_range(0, 400)));
    return m;
  endfunction

  task automatic drain();
    while (matrix_q.size() != 0 || angles_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_limit(logic [14:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_gimbal_limit <= v;
    limit_model = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] ext[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd16384, 16'hC000};
    logic [14:0] limits[6] = '{15'd0, 15'h7FFF, 15'd16384, 15'd16383, 15'd11585, 15'd1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (ext[i]) matrix_q.insert(matrix_q.size(), {7{ext[i]}});
    matrix_q.insert(matrix_q.size(), '0);
    matrix_q.insert(matrix_q.size(),
                    {16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0});
    matrix_q.insert(matrix_q.size(),
                    {16'd16384, 16'd0, 16'hC000, 16'd5, 16'd7, 16'd0, 16'd0});
    matrix_q.insert(matrix_q.size(),
                    {16'd16384, 16'd0, 16'd16384, 16'hFFFB, 16'd7, 16'd0, 16'd0});
    matrix_q.insert(matrix_q.size(),
                    {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                     16'h8000});
    for (int i = 0; i < 10; i++) matrix_q.insert(matrix_q.size(), rnd_matrix());
    drain();
    foreach (limits[p]) begin
      set_limit(limits[p]);
      matrix_q.insert(matrix_q.size(), {16'h1, 16'h2, 16'd0, 16'h3, 16'h4, 16'h5, 16'h6});
      for (int i = 0; i < 60; i++) matrix_q.insert(matrix_q.size(), rnd_matrix());
      if (p == 5) idle_en = 1'b0;
      if (p == 2) begin
        while (matrix_q.size() > 30) @(posedge clk);
        hold = 1'b1;
        while (angles_q.size() != 0) @(posedge clk);
        hold = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== rotation_matrix_to_euler_xyz_core.f =====
hw/rtl/rme_pkg.sv
hw/rtl/rme_cordic.sv
hw/rtl/rme_isqrt.sv
hw/rtl/rotation_matrix_to_euler_xyz_core.sv
hw/rtl/rme_checker.sv
tb/sv/rotation_matrix_to_euler_xyz_core_tb.sv
